// ===== hw/rtl/mm_pkg.sv =====
// mm_pkg: shared constants, request/result payload types, the controller/datapath
// command and status structs and the controller states of the matrix multiplier.
// No dependencies.
`timescale 1ns / 1ps

package mm_pkg;

  // Default sizing of the element stores
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // Fixed field widths of the ports
  localparam int REQ_TYPE_W = 2;
  localparam int ROW_W      = 3;
  localparam int VALUE_W    = 16;
  localparam int ACC_W      = 36;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_START  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd4;

  // Input request payload
  typedef struct packed {
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [ROW_W-1:0]         elem_row;
    logic [ROW_W-1:0]         elem_col;
    logic signed [VALUE_W-1:0] elem_value;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [ROW_W-1:0]         out_row;
    logic [ROW_W-1:0]         out_col;
    logic signed [ACC_W-1:0]  product_value;
    logic                     last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_a;     // write element into A store
    logic wr_b;     // write element into B store
    logic issue;    // issue one inner-product term
    logic first;    // first term of a product element
    logic last_k;   // final term of a product element
    logic zero;     // empty inner dimension: term counts as zero
    logic last;     // final term of the run
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
  } stat_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage

// ===== hw/rtl/matrix_multiply.sv =====
// matrix_multiply: top level of the naive fixed-point matrix multiplier.
// Depends on mm_pkg, mm_ctrl, mm_datapath and mm_ram.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. Load
// requests write one Q8.8 element of A or B; busy stays low, so loads
// can follow each other every cycle. A start request runs the product
// P = A * B: from the next cycle on the sequencer issues one inner-product
// term per cycle, rows_a * cols_b * max(inner_size, 1) terms in all (each
// size capped at MAX_DIM), through the store read, multiply and accumulate
// stages, and busy then stays high while the pipeline empties. Results come
// in row-major order, each on res_o for exactly one cycle with res_strobe_o
// high, the final one with last set; each is registered after the last of
// its terms has passed the store read, multiply and accumulate stages.
// There is no back-pressure on results: the receiver must take every strobe.
// A start with rows_a or cols_b of zero gives no results and leaves busy low.
// Store entries are not cleared at reset; load every element a run reads.

module matrix_multiply #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mm_pkg::req_t                  req_i,
  input  logic                          cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          res_strobe_o,
  output mm_pkg::res_t                  res_o
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  mm_pkg::ctrl_t    ctrl;
  mm_pkg::stat_t    stat;
  logic [IDX_W-1:0] idx_i, idx_j, idx_k;

  // sequencer
  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .i_o        (idx_i),
    .j_o        (idx_j),
    .k_o        (idx_k)
  );

  // stores and arithmetic
  mm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .ctrl_i       (ctrl),
    .i_i          (idx_i),
    .j_i          (idx_j),
    .k_i          (idx_k),
    .stat_o       (stat),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

// ===== hw/rtl/mm_ram.sv =====
// mm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mm_ctrl.sv =====
// mm_ctrl: configuration registers, request decode and the i/j/k sequencer
// of the matrix multiplier. Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CNT_W  = $clog2(MAX_DIM + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mm_pkg::req_t                  req_i,
  input  logic                          cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  mm_pkg::stat_t                 stat_i,
  output mm_pkg::ctrl_t                 ctrl_o,
  output logic [IDX_W-1:0]              i_o,
  output logic [IDX_W-1:0]              j_o,
  output logic [IDX_W-1:0]              k_o
);

  logic [mm_pkg::CFG_DATA_W-1:0] rows_q, inner_q, cols_q;
  mm_pkg::state_e                state_q, state_d;
  logic [IDX_W-1:0]              i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0]              nr, nk, nc;
  logic                          accept, in_range, start_go;
  logic                          last_i, last_j, last_k, last_all;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mm_pkg::DIM_RESET;
      inner_q <= mm_pkg::DIM_RESET;
      cols_q  <= mm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mm_pkg::CFG_ROWS_A: rows_q  <= cfg_data_i;
        mm_pkg::CFG_INNER:  inner_q <= cfg_data_i;
        mm_pkg::CFG_COLS_B: cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dimensions clamped to the store size
  assign nr = (32'(rows_q)  > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(rows_q);
  assign nk = (32'(inner_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(inner_q);
  assign nc = (32'(cols_q)  > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cols_q);

  // request decode
  assign busy     = (state_q != mm_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(req_i.elem_row) < MAX_DIM) && (32'(req_i.elem_col) < MAX_DIM);
  assign start_go = accept && (req_i.req_type == mm_pkg::REQ_START) &&
                    (nr != '0) && (nc != '0);

  // loop end flags
  assign last_i   = (CNT_W'(i_q) == nr - 1'b1);
  assign last_j   = (CNT_W'(j_q) == nc - 1'b1);
  assign last_k   = (nk == '0) || (CNT_W'(k_q) == nk - 1'b1);
  assign last_all = last_k && last_j && last_i;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      mm_pkg::ST_IDLE: begin
        if (start_go) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        if (last_k) begin
          k_d = '0;
          if (last_j) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
        if (last_all) begin
          state_d = mm_pkg::ST_DRAIN;
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = mm_pkg::ST_IDLE;
        end
      end
      default: state_d = mm_pkg::ST_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // commands to the datapath
  always_comb begin
    ctrl_o.wr_a   = accept && in_range && (req_i.req_type == mm_pkg::REQ_LOAD_A);
    ctrl_o.wr_b   = accept && in_range && (req_i.req_type == mm_pkg::REQ_LOAD_B);
    ctrl_o.issue  = (state_q == mm_pkg::ST_RUN);
    ctrl_o.first  = (k_q == '0);
    ctrl_o.last_k = last_k;
    ctrl_o.zero   = (nk == '0);
    ctrl_o.last   = last_all;
  end

  assign i_o = i_q;
  assign j_o = j_q;
  assign k_o = k_q;

endmodule

// ===== hw/rtl/mm_datapath.sv =====
// mm_datapath: A and B element stores, multiply stage, accumulator and
// result register. Depends on mm_pkg and mm_ram.
`timescale 1ns / 1ps

module mm_datapath #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF,
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int DEPTH     = MAX_DIM * MAX_DIM,
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mm_pkg::req_t     req_i,
  input  mm_pkg::ctrl_t    ctrl_i,
  input  logic [IDX_W-1:0] i_i,
  input  logic [IDX_W-1:0] j_i,
  input  logic [IDX_W-1:0] k_i,
  output mm_pkg::stat_t    stat_o,
  output logic             res_strobe_o,
  output mm_pkg::res_t     res_o
);

  localparam int ACC_W = mm_pkg::ACC_W;

  logic [ADDR_W-1:0]           waddr, raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0]       wdata, rdata_a, rdata_b;
  logic                        s1_vld_q, s2_vld_q, res_vld_q;
  logic                        s1_first_q, s1_last_k_q, s1_zero_q, s1_last_q;
  logic                        s2_first_q, s2_last_k_q, s2_zero_q, s2_last_q;
  logic [IDX_W-1:0]            s1_i_q, s1_j_q, s2_i_q, s2_j_q;
  logic signed [2*ELEM_WIDTH-1:0] prod_q;
  logic [ACC_W-1:0]            acc_q, term, sum;
  mm_pkg::res_t                res_q;

  // store addressing: element (r, c) lives at r*MAX_DIM + c
  assign waddr   = ADDR_W'(32'(req_i.elem_row) * MAX_DIM + 32'(req_i.elem_col));
  assign wdata   = ELEM_WIDTH'($unsigned(req_i.elem_value));
  assign raddr_a = ADDR_W'(32'(i_i) * MAX_DIM + 32'(k_i));
  assign raddr_b = ADDR_W'(32'(k_i) * MAX_DIM + 32'(j_i));

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= ctrl_i.issue;
      s2_vld_q  <= s1_vld_q;
      res_vld_q <= s2_vld_q && s2_last_k_q;
    end
  end

  // stage 1: tags travel alongside the store read
  always_ff @(posedge clk_i) begin
    s1_first_q  <= ctrl_i.first;
    s1_last_k_q <= ctrl_i.last_k;
    s1_zero_q   <= ctrl_i.zero;
    s1_last_q   <= ctrl_i.last;
    s1_i_q      <= i_i;
    s1_j_q      <= j_i;
  end

  // stage 2: signed element product
  always_ff @(posedge clk_i) begin
    prod_q      <= $signed(rdata_a) * $signed(rdata_b);
    s2_first_q  <= s1_first_q;
    s2_last_k_q <= s1_last_k_q;
    s2_zero_q   <= s1_zero_q;
    s2_last_q   <= s1_last_q;
    s2_i_q      <= s1_i_q;
    s2_j_q      <= s1_j_q;
  end

  // stage 3: accumulate, wrapping at the result width
  assign term = s2_zero_q ? '0 : ACC_W'(prod_q);
  assign sum  = (s2_first_q ? '0 : acc_q) + term;

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= sum;
    end
    if (s2_vld_q && s2_last_k_q) begin
      res_q.out_row       <= mm_pkg::ROW_W'(s2_i_q);
      res_q.out_col       <= mm_pkg::ROW_W'(s2_j_q);
      res_q.product_value <= $signed(sum);
      res_q.last          <= s2_last_q;
    end
  end

  assign stat_o.pipe_busy = s1_vld_q || s2_vld_q || res_vld_q;
  assign res_strobe_o     = res_vld_q;
  assign res_o            = res_q;

endmodule
